### rtl/bmf_pkg.sv
// Shared constants, types and helper functions of the 3x3 box mean filter.
`default_nettype none
package bmf_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH     = 1024;
    localparam int ADDR_W        = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT    = 4096;

    // Register and counter widths.
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int ROW_W         = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Register values after reset.
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

    // Channels of a pixel.
    localparam int NUM_CH   = 3;
    localparam int CH_W     = 8;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Results a single request can produce, in delivery order.
    localparam int NUM_EMIT       = 4;
    localparam int EMIT_MID_MID   = 0;
    localparam int EMIT_MID_LAST  = 1;
    localparam int EMIT_LAST_MID  = 2;
    localparam int EMIT_LAST_LAST = 3;
    localparam int EMIT_CNT_W     = $clog2(NUM_EMIT + 1);

    // Sum widths: one window column, then the full neighbourhood.
    localparam int SUM_COL_W = 10;
    localparam int SUM_W     = 12;

    // Result queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RESV_W     = FIFO_CNT_W + 1;

    // Reciprocal of nine, exact for every sum below 32768.
    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(7282);

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pixel;
    typedef t_pixel [2:0][2:0]           t_window;
    typedef t_pixel [NUM_EMIT-1:0]       t_mean_set;
    typedef logic [NUM_EMIT-1:0]         t_emit;

    typedef struct packed {
        logic  row_zero;
        logic  row_one;
        logic  col_zero;
        t_emit emit;
    } t_step_ctl;

    typedef struct packed {
        t_pixel mean;
        logic   frame_done;
    } t_result;

    // Truncating division by nine through a reciprocal multiply.
    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [SUM_W+DIV9_MUL_W-1:0] prod;
        prod = (SUM_W + DIV9_MUL_W)'(sum) * (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
        return prod[DIV9_SHIFT +: CH_W];
    endfunction

endpackage
`default_nettype wire

### rtl/box_mean_filter_3x3_rgb.sv
// Top level of the 3x3 box mean filter: counters, configuration and the result queue.
// A request's results pass the read, window and column-sum registers before they are written
// to the queue, whose head is offered. Throughput: one request per cycle while o_stall is low,
// halved on a frame's last row where most requests give two results; input stall rises while
// the 16-entry queue, with results in the three pipeline stages, has no room for four more.
// Synchronous active-low reset clears counters, window and queue and restores 640x480.
`default_nettype none
module box_mean_filter_3x3_rgb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bmf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_blue_in,
    input  logic [7:0]                      i_green_in,
    input  logic [7:0]                      i_red_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_blue_mean,
    output logic [7:0]                      o_green_mean,
    output logic [7:0]                      o_red_mean,
    output logic                            o_frame_done
);
    import bmf_pkg::*;

    logic [WIDTH_W-1:0]    r_frame_width;
    logic [HEIGHT_W-1:0]   r_frame_height;
    logic [ADDR_W-1:0]     r_col;
    logic [ROW_W-1:0]      r_row;
    logic [EMIT_CNT_W-1:0] r_cnt1;
    logic [EMIT_CNT_W-1:0] r_cnt2;
    logic [EMIT_CNT_W-1:0] r_cnt3;
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_cnt;

    logic [WIDTH_W-1:0]    width_eff;
    logic [HEIGHT_W-1:0]   height_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  in_acc;
    logic                  out_acc;
    t_pixel                cur;
    t_step_ctl             step_ctl;
    logic [EMIT_CNT_W-1:0] step_cnt;
    logic [RESV_W-1:0]     reserved;

    logic                  win_valid;
    t_window               win;
    t_emit                 win_emit;
    logic                  mean_valid;
    t_emit                 mean_emit;
    t_mean_set             mean;
    logic [FIFO_PTR_W-1:0] slot_off  [NUM_EMIT];
    logic [FIFO_PTR_W-1:0] slot_addr [NUM_EMIT];
    t_result               head;

    // Effective frame size, with out-of-range settings clamped.
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (r_frame_width > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            height_eff = HEIGHT_W'(1);
        end else if (r_frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_frame_height;
        end
    end

    // Position flags and the results this request will produce.
    always_comb begin
        last_col = (WIDTH_W'(r_col) == (width_eff - WIDTH_W'(1)));
        last_row = (HEIGHT_W'(r_row) == (height_eff - HEIGHT_W'(1)));
        step_ctl.row_zero = (r_row == '0);
        step_ctl.row_one  = (r_row == ROW_W'(1));
        step_ctl.col_zero = (r_col == '0);
        step_ctl.emit[EMIT_MID_MID]   = (r_row != '0) && (r_col != '0);
        step_ctl.emit[EMIT_MID_LAST]  = (r_row != '0) && last_col;
        step_ctl.emit[EMIT_LAST_MID]  = last_row && (r_col != '0);
        step_ctl.emit[EMIT_LAST_LAST] = last_row && last_col;
        step_cnt = EMIT_CNT_W'($countones(step_ctl.emit));
        cur[CH_BLUE]  = i_blue_in;
        cur[CH_GREEN] = i_green_in;
        cur[CH_RED]   = i_red_in;
    end

    // Room check: queue fill plus results still in flight, leaving space for four.
    always_comb begin
        reserved = RESV_W'(r_fifo_cnt) + RESV_W'(r_cnt1) + RESV_W'(r_cnt2) +
                   RESV_W'(r_cnt3);
        o_stall  = (reserved > RESV_W'(FIFO_DEPTH - NUM_EMIT));
    end

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Configuration registers and raster counters; any register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            priority if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                    default:          r_frame_width  <= r_frame_width;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end else begin
                r_col <= r_col;
                r_row <= r_row;
            end
        end
    end

    bmf_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_acc),
        .i_col    (r_col),
        .i_pixel  (cur),
        .i_ctl    (step_ctl),
        .o_valid  (win_valid),
        .o_window (win),
        .o_emit   (win_emit)
    );

    bmf_mean u_mean (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (win_valid),
        .i_window (win),
        .i_emit   (win_emit),
        .o_valid  (mean_valid),
        .o_emit   (mean_emit),
        .o_mean   (mean)
    );

    // Queue slots for the results of one request, packed in delivery order.
    always_comb begin
        slot_off[0] = '0;
        for (int k = 1; k < NUM_EMIT; k++) begin
            slot_off[k] = slot_off[k-1] + FIFO_PTR_W'(mean_emit[k-1]);
        end
        for (int k = 0; k < NUM_EMIT; k++) begin
            slot_addr[k] = r_wr_ptr + slot_off[k];
        end
    end

    // Result counts travelling alongside the pipeline, and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_cnt3     <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            r_cnt1     <= in_acc ? step_cnt : '0;
            r_cnt2     <= r_cnt1;
            r_cnt3     <= r_cnt2;
            r_wr_ptr   <= r_wr_ptr + FIFO_PTR_W'(r_cnt3);
            r_rd_ptr   <= r_rd_ptr + FIFO_PTR_W'(out_acc);
            r_fifo_cnt <= r_fifo_cnt + FIFO_CNT_W'(r_cnt3) - FIFO_CNT_W'(out_acc);
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (mean_valid) begin
            for (int k = 0; k < NUM_EMIT; k++) begin
                if (mean_emit[k]) begin
                    r_fifo[slot_addr[k]] <= '{mean: mean[k],
                                              frame_done: (k == EMIT_LAST_LAST)};
                end
            end
        end
    end

    // Output from the head of the queue.
    always_comb begin
        head         = r_fifo[r_rd_ptr];
        o_valid      = (r_fifo_cnt != '0);
        o_blue_mean  = head.mean[CH_BLUE];
        o_green_mean = head.mean[CH_GREEN];
        o_red_mean   = head.mean[CH_RED];
        o_frame_done = head.frame_done;
    end

endmodule
`default_nettype wire

### rtl/bmf_window.sv
// Line stores with read-modify-write forwarding and the 3x3 window registers.
`default_nettype none
module bmf_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [bmf_pkg::ADDR_W-1:0] i_col,
    input  bmf_pkg::t_pixel    i_pixel,
    input  bmf_pkg::t_step_ctl i_ctl,
    output logic               o_valid,
    output bmf_pkg::t_window   o_window,
    output bmf_pkg::t_emit     o_emit
);
    import bmf_pkg::*;

    t_pixel mem_upper [MAX_WIDTH];
    t_pixel mem_lower [MAX_WIDTH];

    t_pixel            r_rd_upper;
    t_pixel            r_rd_lower;
    logic              r_fwd;
    t_pixel            r_fwd_upper;
    t_pixel            r_fwd_lower;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_col;
    t_pixel            r_s1_pixel;
    t_step_ctl         r_s1_ctl;
    t_window           r_win;
    t_window           n_win;
    logic              r_out_valid;
    t_emit             r_out_emit;

    t_pixel            low;
    t_pixel            up;
    t_pixel            wr_upper;
    t_pixel [2:0]      new_col;

    // Take the stored rows, preferring the forwarded entry when the read met a write to its column.
    always_comb begin
        low = r_fwd ? r_fwd_lower : r_rd_lower;
        up  = r_fwd ? r_fwd_upper : r_rd_upper;
        if (r_s1_ctl.row_zero) begin
            new_col[0] = r_s1_pixel;
            new_col[1] = r_s1_pixel;
        end else if (r_s1_ctl.row_one) begin
            new_col[0] = low;
            new_col[1] = low;
        end else begin
            new_col[0] = up;
            new_col[1] = low;
        end
        new_col[2] = r_s1_pixel;
        wr_upper   = r_s1_ctl.row_zero ? r_s1_pixel : low;
    end

    // Line stores: read when a request is taken, write back in the cycle after.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_upper[r_s1_col] <= wr_upper;
            mem_lower[r_s1_col] <= r_s1_pixel;
        end
        if (i_push) begin
            r_rd_upper <= mem_upper[i_col];
            r_rd_lower <= mem_lower[i_col];
        end
    end

    // Shift the window; the first column of a row fills the left border.
    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            if (r_s1_ctl.col_zero) begin
                n_win[i][0] = new_col[i];
                n_win[i][1] = new_col[i];
            end else begin
                n_win[i][0] = r_win[i][1];
                n_win[i][1] = r_win[i][2];
            end
            n_win[i][2] = new_col[i];
        end
    end

    // Control of the read stage and the window stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            r_s1_valid  <= i_push;
            r_out_valid <= r_s1_valid;
            if (i_push) begin
                r_fwd <= r_s1_valid && (r_s1_col == i_col);
            end
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
    end

    // Payload of the read stage and the forwarded write data.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_col    <= i_col;
            r_s1_pixel  <= i_pixel;
            r_s1_ctl    <= i_ctl;
            r_fwd_upper <= wr_upper;
            r_fwd_lower <= r_s1_pixel;
        end
        r_out_emit <= r_s1_ctl.emit;
    end

    assign o_valid  = r_out_valid;
    assign o_window = r_win;
    assign o_emit   = r_out_emit;

endmodule
`default_nettype wire

### rtl/bmf_mean.sv
// Column sums, neighbourhood totals and division by nine for the four result kinds.
`default_nettype none
module bmf_mean (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bmf_pkg::t_window   i_window,
    input  bmf_pkg::t_emit     i_emit,
    output logic               o_valid,
    output bmf_pkg::t_emit     o_emit,
    output bmf_pkg::t_mean_set o_mean
);
    import bmf_pkg::*;

    logic [SUM_COL_W-1:0] n_cm [3][NUM_CH];
    logic [SUM_COL_W-1:0] n_cl [3][NUM_CH];
    logic [SUM_COL_W-1:0] r_cm [3][NUM_CH];
    logic [SUM_COL_W-1:0] r_cl [3][NUM_CH];
    logic                 r_valid;
    t_emit                r_emit;
    logic [SUM_W-1:0]     tot  [NUM_EMIT][NUM_CH];

    // Column sums: all three rows, and the bottom-border form with the last row doubled.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                n_cm[j][ch] = SUM_COL_W'(i_window[0][j][ch]) +
                              SUM_COL_W'(i_window[1][j][ch]) +
                              SUM_COL_W'(i_window[2][j][ch]);
                n_cl[j][ch] = SUM_COL_W'(i_window[1][j][ch]) +
                              SUM_COL_W'({i_window[2][j][ch], 1'b0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cm   <= n_cm;
        r_cl   <= n_cl;
        r_emit <= i_emit;
    end

    // Totals over three columns, or with the right border column doubled.
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tot[EMIT_MID_MID][ch]   = SUM_W'(r_cm[0][ch]) + SUM_W'(r_cm[1][ch]) +
                                      SUM_W'(r_cm[2][ch]);
            tot[EMIT_MID_LAST][ch]  = SUM_W'(r_cm[1][ch]) + SUM_W'({r_cm[2][ch], 1'b0});
            tot[EMIT_LAST_MID][ch]  = SUM_W'(r_cl[0][ch]) + SUM_W'(r_cl[1][ch]) +
                                      SUM_W'(r_cl[2][ch]);
            tot[EMIT_LAST_LAST][ch] = SUM_W'(r_cl[1][ch]) + SUM_W'({r_cl[2][ch], 1'b0});
        end
        for (int k = 0; k < NUM_EMIT; k++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                o_mean[k][ch] = div9(tot[k][ch]);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_emit  = r_emit;

endmodule
`default_nettype wire

### rtl/bmf_checker.sv
// Port-level checks of the 3x3 box mean filter and their binding to the top level.
`default_nettype none
module bmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_blue_mean,
    input logic [7:0] o_green_mean,
    input logic [7:0] o_red_mean,
    input logic       o_frame_done
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // Reset leaves room for new requests.
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // An empty queue only refills from a request taken earlier, after the read, window and column-sum stages.
    a_fill_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 4))
        else $error("result appeared without a matching request");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result withdrawn");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_blue_mean) && $stable(o_green_mean) &&
            $stable(o_red_mean) && $stable(o_frame_done))
        else $error("stalled result changed");

endmodule

bind box_mean_filter_3x3_rgb bmf_checker u_bmf_checker (.*);
`default_nettype wire
